>>> hdl/smag_pkg.sv
package smag_pkg;

  // Fixed field widths of the request and result channels
  localparam int OP_W      = 2;
  localparam int ORIGIN_W  = 9;
  localparam int OFFSET_W  = 6;
  localparam int SUM_W     = ORIGIN_W + 1;
  localparam int WEIGHT_W  = 16;
  localparam int PIXEL_W   = 10;
  localparam int LINE_W    = 12;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Request opcodes; the unused code falls to read
  typedef enum logic [OP_W-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hdl/smag_front.sv
// Request front end: forms the cell address, range check, weight masking.
module smag_front #(
  parameter int GRID_COLS   = 512,
  parameter int GRID_ROWS   = 512,
  parameter int WEIGHT_BITS = 16,
  localparam int AW     = $clog2(GRID_COLS * GRID_ROWS),
  localparam int DATA_W = smag_pkg::OP_W + 1 + AW + WEIGHT_BITS
                          + smag_pkg::PIXEL_W + smag_pkg::LINE_W
) (
  input  logic                          start_i,
  input  smag_pkg::q_stat_t             q_stat_i,
  input  logic                          clearing_i,
  input  logic [smag_pkg::OP_W-1:0]     op_i,
  input  logic [smag_pkg::ORIGIN_W-1:0] col_origin_i,
  input  logic [smag_pkg::ORIGIN_W-1:0] row_origin_i,
  input  logic [smag_pkg::OFFSET_W-1:0] col_in_window_i,
  input  logic [smag_pkg::OFFSET_W-1:0] row_in_window_i,
  input  logic [smag_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [smag_pkg::PIXEL_W-1:0]  pixel_tag_i,
  input  logic [smag_pkg::LINE_W-1:0]   line_tag_i,
  output logic                          busy_o,
  output logic                          push_o,
  output logic [DATA_W-1:0]             push_data_o
);

  localparam int WIN = (WEIGHT_BITS < smag_pkg::WEIGHT_W) ? WEIGHT_BITS : smag_pkg::WEIGHT_W;

  logic [smag_pkg::SUM_W-1:0] col_sum;
  logic [smag_pkg::SUM_W-1:0] row_sum;
  logic [31:0]                idx_wide;
  logic                       oor;
  logic [AW-1:0]              idx;
  logic [WEIGHT_BITS-1:0]     w;

  assign col_sum  = smag_pkg::SUM_W'(col_origin_i) + smag_pkg::SUM_W'(col_in_window_i);
  assign row_sum  = smag_pkg::SUM_W'(row_origin_i) + smag_pkg::SUM_W'(row_in_window_i);
  assign oor      = (32'(col_sum) >= 32'(GRID_COLS)) || (32'(row_sum) >= 32'(GRID_ROWS));
  // row-major cell index, multiply by a constant
  assign idx_wide = 32'(row_sum) * 32'(GRID_COLS) + 32'(col_sum);
  assign idx      = oor ? '0 : idx_wide[AW-1:0];
  assign w        = WEIGHT_BITS'(weight_i[WIN-1:0]);

  assign busy_o      = clearing_i || q_stat_i.full;
  assign push_o      = start_i && !busy_o;
  assign push_data_o = {op_i, oor, idx, w, pixel_tag_i, line_tag_i};

endmodule

>>> hdl/smag_fifo.sv
// Small request queue between front and back.
module smag_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output smag_pkg::q_stat_t stat_o
);

  localparam int PW = $clog2(smag_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(smag_pkg::QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_q [smag_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(smag_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !pop_i)
    else $error("pop from empty queue");

endmodule

>>> hdl/smag_back.sv
// Back end: grid store, clearing pass, read-compare-write, result register.
module smag_back #(
  parameter int GRID_COLS   = 512,
  parameter int GRID_ROWS   = 512,
  parameter int WEIGHT_BITS = 16,
  localparam int AW     = $clog2(GRID_COLS * GRID_ROWS),
  localparam int DATA_W = smag_pkg::OP_W + 1 + AW + WEIGHT_BITS
                          + smag_pkg::PIXEL_W + smag_pkg::LINE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [DATA_W-1:0]             q_data_i,
  input  smag_pkg::q_stat_t             q_stat_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          result_valid_o,
  output logic [smag_pkg::WEIGHT_W-1:0] cell_weight_o,
  output logic [smag_pkg::PIXEL_W-1:0]  cell_pixel_o,
  output logic [smag_pkg::LINE_W-1:0]   cell_line_o,
  output logic                          updated_o,
  output logic                          out_of_range_o
);

  localparam int CELLS   = GRID_COLS * GRID_ROWS;
  localparam int ENT_W   = WEIGHT_BITS + smag_pkg::PIXEL_W + smag_pkg::LINE_W;
  localparam int IDX_LSB = ENT_W;
  localparam int WIN = (WEIGHT_BITS < smag_pkg::WEIGHT_W) ? WEIGHT_BITS : smag_pkg::WEIGHT_W;

  smag_pkg::bk_state_e state_q, state_d;

  logic [ENT_W-1:0]  mem [CELLS];
  logic [ENT_W-1:0]  rd_q;
  logic [DATA_W-1:0] item_q;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic              clr_done;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;

  // current item fields
  logic [smag_pkg::OP_W-1:0]    it_op;
  logic                         it_oor;
  logic [AW-1:0]                it_idx;
  logic [WEIGHT_BITS-1:0]       it_w;
  logic [smag_pkg::PIXEL_W-1:0] it_pix;
  logic [smag_pkg::LINE_W-1:0]  it_line;

  // stored entry as read
  logic [WEIGHT_BITS-1:0]       rd_w;
  logic [smag_pkg::PIXEL_W-1:0] rd_pix;
  logic [smag_pkg::LINE_W-1:0]  rd_line;

  // entry after the operation
  logic [WEIGHT_BITS-1:0]       new_w;
  logic [smag_pkg::PIXEL_W-1:0] new_pix;
  logic [smag_pkg::LINE_W-1:0]  new_line;
  logic                         upd;

  logic                          res_valid_q, res_valid_d;
  logic [smag_pkg::WEIGHT_W-1:0] res_weight_q, res_weight_d;
  logic [smag_pkg::PIXEL_W-1:0]  res_pixel_q, res_pixel_d;
  logic [smag_pkg::LINE_W-1:0]   res_line_q, res_line_d;
  logic                          res_upd_q, res_upd_d;
  logic                          res_oor_q, res_oor_d;

  assign {it_op, it_oor, it_idx, it_w, it_pix, it_line} = item_q;
  assign {rd_w, rd_pix, rd_line} = rd_q;
  assign clr_done = (clr_cnt_q == AW'(CELLS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smag_pkg::BK_CLEAR: begin
        if (clr_done) begin
          state_d = smag_pkg::BK_IDLE;
        end
      end
      smag_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = smag_pkg::BK_EXEC;
        end
      end
      smag_pkg::BK_EXEC: begin
        state_d = smag_pkg::BK_IDLE;
      end
      default: begin
        state_d = smag_pkg::BK_CLEAR;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o       = 1'b0;
    clearing_o  = 1'b0;
    clr_cnt_d   = clr_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = it_idx;
    mem_wdata   = '0;
    new_w       = rd_w;
    new_pix     = rd_pix;
    new_line    = rd_line;
    upd         = 1'b0;
    res_valid_d = 1'b0;
    case (state_q)
      smag_pkg::BK_CLEAR: begin
        clearing_o = 1'b1;
        mem_we     = 1'b1;
        mem_waddr  = clr_cnt_q;
        clr_cnt_d  = clr_cnt_q + AW'(1);
      end
      smag_pkg::BK_IDLE: begin
        pop_o = !q_stat_i.empty;
      end
      smag_pkg::BK_EXEC: begin
        res_valid_d = 1'b1;
        if (!it_oor) begin
          case (smag_pkg::op_e'(it_op))
            smag_pkg::OP_ACCUM: begin
              if (it_w > rd_w) begin
                new_w    = it_w;
                new_pix  = it_pix;
                new_line = it_line;
                upd      = 1'b1;
                mem_we   = 1'b1;
              end
            end
            smag_pkg::OP_CLEAR: begin
              new_w    = '0;
              new_pix  = '0;
              new_line = '0;
              mem_we   = 1'b1;
            end
            default: begin
            end
          endcase
          mem_wdata = {new_w, new_pix, new_line};
        end
      end
      default: begin
      end
    endcase
  end

  assign res_weight_d = it_oor ? '0 : smag_pkg::WEIGHT_W'(new_w[WIN-1:0]);
  assign res_pixel_d  = it_oor ? '0 : new_pix;
  assign res_line_d   = it_oor ? '0 : new_line;
  assign res_upd_d    = upd;
  assign res_oor_d    = it_oor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smag_pkg::BK_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // grid store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rd_q <= mem[q_data_i[IDX_LSB +: AW]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_data_i;
    end
    if (res_valid_d) begin
      res_weight_q <= res_weight_d;
      res_pixel_q  <= res_pixel_d;
      res_line_q   <= res_line_d;
      res_upd_q    <= res_upd_d;
      res_oor_q    <= res_oor_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign cell_weight_o  = res_weight_q;
  assign cell_pixel_o   = res_pixel_q;
  assign cell_line_o    = res_line_q;
  assign updated_o      = res_upd_q;
  assign out_of_range_o = res_oor_q;

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == smag_pkg::BK_EXEC))
    else $error("result without execute step");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_oor_q) |->
      (res_weight_q == '0 && res_pixel_q == '0 && res_line_q == '0 && !res_upd_q))
    else $error("out of range result carries data");

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == smag_pkg::BK_CLEAR) |-> (!pop_o && !res_valid_d))
    else $error("request taken during clearing pass");

endmodule

>>> hdl/scatter_max_argmax_grid.sv
// Max projection grid with argmax tags.
// Request channel: start with op_i and the address, weight and tag fields;
// a request is taken at a rising edge where start is high and busy is low.
// op accumulate keeps the larger weight (strictly greater wins) with its
// pixel and line tags, read returns the cell, clear zeroes it; the unused
// opcode reads. A cell outside the grid is left alone and flagged.
// Result channel: result_valid_o strobes for one cycle with the cell
// contents after the operation; the receiver cannot hold results off.
// The result strobe follows the request through the queue, the item and
// read registers, and the result register. The back end handles one request
// at a time: it reads the cell, then compares and writes, then takes the next.
// The front end computes the cell address and range check and pushes into
// a 2-entry queue; busy is high while that queue is full.
// Reset: the grid memory is swept to zero, one cell per cycle, over all
// GRID_COLS * GRID_ROWS cells (262144 at default size); busy stays high
// throughout and no request is taken.
module scatter_max_argmax_grid #(
  parameter int GRID_COLS   = 512,
  parameter int GRID_ROWS   = 512,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [smag_pkg::OP_W-1:0]     op_i,
  input  logic [smag_pkg::ORIGIN_W-1:0] col_origin_i,
  input  logic [smag_pkg::ORIGIN_W-1:0] row_origin_i,
  input  logic [smag_pkg::OFFSET_W-1:0] col_in_window_i,
  input  logic [smag_pkg::OFFSET_W-1:0] row_in_window_i,
  input  logic [smag_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [smag_pkg::PIXEL_W-1:0]  pixel_tag_i,
  input  logic [smag_pkg::LINE_W-1:0]   line_tag_i,
  output logic                          result_valid_o,
  output logic [smag_pkg::WEIGHT_W-1:0] cell_weight_o,
  output logic [smag_pkg::PIXEL_W-1:0]  cell_pixel_o,
  output logic [smag_pkg::LINE_W-1:0]   cell_line_o,
  output logic                          updated_o,
  output logic                          out_of_range_o
);

  localparam int AW     = $clog2(GRID_COLS * GRID_ROWS);
  localparam int DATA_W = smag_pkg::OP_W + 1 + AW + WEIGHT_BITS
                          + smag_pkg::PIXEL_W + smag_pkg::LINE_W;

  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              pop;
  logic [DATA_W-1:0] head_data;
  smag_pkg::q_stat_t q_stat;
  logic              clearing;

  // front: address, range check, accept
  smag_front #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_front (
    .start_i        (start),
    .q_stat_i       (q_stat),
    .clearing_i     (clearing),
    .op_i           (op_i),
    .col_origin_i   (col_origin_i),
    .row_origin_i   (row_origin_i),
    .col_in_window_i(col_in_window_i),
    .row_in_window_i(row_in_window_i),
    .weight_i       (weight_i),
    .pixel_tag_i    (pixel_tag_i),
    .line_tag_i     (line_tag_i),
    .busy_o         (busy),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // classified requests waiting for the store
  smag_fifo #(
    .DATA_W(DATA_W)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(push_data),
    .pop_i (pop),
    .data_o(head_data),
    .stat_o(q_stat)
  );

  // back: grid memory read-compare-write and result register
  smag_back #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_data_i      (head_data),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .result_valid_o(result_valid_o),
    .cell_weight_o (cell_weight_o),
    .cell_pixel_o  (cell_pixel_o),
    .cell_line_o   (cell_line_o),
    .updated_o     (updated_o),
    .out_of_range_o(out_of_range_o)
  );

endmodule
